// File: rtl/twg_pkg.sv
`default_nettype none

package twg_pkg;

    // Phase resolution: one turn of the waveform is TABLE_SIZE phase steps.
    localparam int unsigned TABLE_SIZE  = 4096;
    localparam int unsigned PHASE_W     = 12;

    // Configuration port
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 24;

    // Register widths
    localparam int unsigned AMP_W       = 24;
    localparam int unsigned OFS_W       = 16;

    // Wave values are Q1.15 in 17 signed bits, so that +1.0 fits.
    localparam int unsigned WAVE_W      = 17;
    localparam logic signed [WAVE_W-1:0] WAVE_ONE = 17'sd32768;

    typedef enum logic [1:0] {
        MODE_CONSTANT = 2'd0,
        MODE_COSINE   = 2'd1,
        MODE_RAMP     = 2'd2,
        MODE_SQUARE   = 2'd3
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WAVEFORM_MODE = 3'd0,
        CFG_PHASE_STEP    = 3'd1,
        CFG_AMPLITUDE_RE  = 3'd2,
        CFG_AMPLITUDE_IM  = 3'd3,
        CFG_OFFSET_RE     = 3'd4,
        CFG_OFFSET_IM     = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic signed [WAVE_W-1:0] re;
        logic signed [WAVE_W-1:0] im;
    } wave_t;

endpackage

`default_nettype wire

// File: rtl/table_waveform_generator_core.sv
`default_nettype none

// Phase-accumulator signal source. Each transfer on the input channel with
// sample_request set yields one complex sample, amplitude times the selected
// unit wave at the current phase plus offset, rounded and saturated to
// OUT_WIDTH bits; the phase then advances by phase_step modulo 4096. A
// transfer with sample_request clear yields nothing and leaves the phase alone.
// One sample is taken in every clock cycle while in_ready is high; the result
// passes the sine/cosine Horner pipeline (seven stages), two stages of complex
// gain and the output register. A two-entry output buffer (output register
// plus skid register) decouples the channels: in_ready comes from a register
// and drops only while the skid register holds a sample, which freezes the
// whole pipeline. Write configuration only while no sample is in flight.
module table_waveform_generator_core #(
    parameter int unsigned OUT_WIDTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Request channel
    input  wire logic                                  in_valid,
    output      logic                                  in_ready,
    input  wire logic                                  sample_request,
    // Sample channel
    output      logic                                  out_valid,
    input  wire logic                                  out_ready,
    output      logic signed [OUT_WIDTH-1:0]           sample_re,
    output      logic signed [OUT_WIDTH-1:0]           sample_im,
    // Configuration writes
    input  wire logic                                  cfg_write,
    input  wire logic [twg_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [twg_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int unsigned PROD_W = twg_pkg::AMP_W + twg_pkg::WAVE_W;
    localparam int unsigned ACC_W  = PROD_W + 1;
    localparam int unsigned RND_W  = ACC_W - 15 + 1;
    localparam int unsigned SUM_W  = RND_W + 1;
    localparam int unsigned CMP_W  = ((OUT_WIDTH > SUM_W) ? OUT_WIDTH : SUM_W) + 1;
    localparam logic signed [CMP_W-1:0] OUT_MAX =
        $signed({{(CMP_W-OUT_WIDTH+1){1'b0}}, {(OUT_WIDTH-1){1'b1}}});
    localparam logic signed [CMP_W-1:0] OUT_MIN = ~OUT_MAX;

    // Divide by 2^15, half away from zero.
    function automatic logic signed [RND_W-1:0] round_q15(
        input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] sum;
        logic [RND_W-2:0] r;
        mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        sum = mag + ACC_W'(16384);
        r = sum[ACC_W-1:15];
        return v[ACC_W-1] ? -$signed({1'b0, r}) : $signed({1'b0, r});
    endfunction

    function automatic logic signed [OUT_WIDTH-1:0] saturate(
        input logic signed [SUM_W-1:0] v);
        logic signed [CMP_W-1:0] v_ext;
        logic signed [CMP_W-1:0] lim;
        v_ext = CMP_W'(v);
        if (v_ext > OUT_MAX)
        begin
            lim = OUT_MAX;
        end
        else if (v_ext < OUT_MIN)
        begin
            lim = OUT_MIN;
        end
        else
        begin
            lim = v_ext;
        end
        return lim[OUT_WIDTH-1:0];
    endfunction

    // Configuration registers
    twg_pkg::mode_t                        mode_reg;
    logic [twg_pkg::PHASE_W-1:0]           phase_step_reg;
    logic signed [twg_pkg::AMP_W-1:0]      amp_re_reg;
    logic signed [twg_pkg::AMP_W-1:0]      amp_im_reg;
    logic signed [twg_pkg::OFS_W-1:0]      ofs_re_reg;
    logic signed [twg_pkg::OFS_W-1:0]      ofs_im_reg;

    logic [twg_pkg::PHASE_W-1:0]           phase_reg;

    logic                                  en;
    logic                                  item;
    logic                                  wave_valid;
    twg_pkg::wave_t                        wave;

    // Gain stages
    logic                                  vld_i_reg;
    logic signed [PROD_W-1:0]              p_rr_reg;
    logic signed [PROD_W-1:0]              p_ii_reg;
    logic signed [PROD_W-1:0]              p_ri_reg;
    logic signed [PROD_W-1:0]              p_ir_reg;
    logic                                  vld_j_reg;
    logic signed [ACC_W-1:0]               acc_re_reg;
    logic signed [ACC_W-1:0]               acc_im_reg;

    logic signed [SUM_W-1:0]               sum_re;
    logic signed [SUM_W-1:0]               sum_im;
    logic signed [OUT_WIDTH-1:0]           res_re;
    logic signed [OUT_WIDTH-1:0]           res_im;

    // Output buffer
    logic                                  out_valid_reg;
    logic signed [OUT_WIDTH-1:0]           out_re_reg;
    logic signed [OUT_WIDTH-1:0]           out_im_reg;
    logic                                  skid_valid_reg;
    logic signed [OUT_WIDTH-1:0]           skid_re_reg;
    logic signed [OUT_WIDTH-1:0]           skid_im_reg;
    logic                                  take;
    logic                                  arrive;

    // Advance the pipeline whenever the skid register is empty.
    assign en       = !skid_valid_reg;
    assign in_ready = !skid_valid_reg;
    assign item     = in_valid && in_ready && sample_request;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= twg_pkg::MODE_CONSTANT;
            phase_step_reg <= '0;
            amp_re_reg     <= 24'sd32767;
            amp_im_reg     <= '0;
            ofs_re_reg     <= '0;
            ofs_im_reg     <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                twg_pkg::CFG_WAVEFORM_MODE: mode_reg <= twg_pkg::mode_t'(cfg_data[1:0]);
                twg_pkg::CFG_PHASE_STEP:    phase_step_reg <= cfg_data[twg_pkg::PHASE_W-1:0];
                twg_pkg::CFG_AMPLITUDE_RE:  amp_re_reg <= $signed(cfg_data[twg_pkg::AMP_W-1:0]);
                twg_pkg::CFG_AMPLITUDE_IM:  amp_im_reg <= $signed(cfg_data[twg_pkg::AMP_W-1:0]);
                twg_pkg::CFG_OFFSET_RE:     ofs_re_reg <= $signed(cfg_data[twg_pkg::OFS_W-1:0]);
                twg_pkg::CFG_OFFSET_IM:     ofs_im_reg <= $signed(cfg_data[twg_pkg::OFS_W-1:0]);
                default:                    ;
            endcase
        end
    end

    // Advance the phase on every requested sample; it wraps at 4096 by width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (item)
        begin
            phase_reg <= phase_reg + phase_step_reg;
        end
    end

    twg_wave u_wave (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (item),
        .phase     (phase_reg),
        .mode      (mode_reg),
        .out_valid (wave_valid),
        .wave      (wave)
    );

    // Complex gain: four products, then the two sums.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_i_reg <= 1'b0;
            vld_j_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_i_reg <= wave_valid;
            vld_j_reg <= vld_i_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_rr_reg   <= amp_re_reg * wave.re;
            p_ii_reg   <= amp_im_reg * wave.im;
            p_ri_reg   <= amp_re_reg * wave.im;
            p_ir_reg   <= amp_im_reg * wave.re;
            acc_re_reg <= ACC_W'(p_rr_reg) - ACC_W'(p_ii_reg);
            acc_im_reg <= ACC_W'(p_ri_reg) + ACC_W'(p_ir_reg);
        end
    end

    // Round, add the offset, clamp to the output width.
    assign sum_re = SUM_W'(round_q15(acc_re_reg)) + SUM_W'(ofs_re_reg);
    assign sum_im = SUM_W'(round_q15(acc_im_reg)) + SUM_W'(ofs_im_reg);
    assign res_re = saturate(sum_re);
    assign res_im = saturate(sum_im);

    // Output register with skid: a sample that finds the output register
    // stalled drops into the skid register and freezes the pipeline.
    assign take   = out_valid_reg && out_ready;
    assign arrive = en && vld_j_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (arrive)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_re_reg <= skid_re_reg;
                out_im_reg <= skid_im_reg;
            end
        end
        else if (arrive)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_re_reg <= res_re;
                skid_im_reg <= res_im;
            end
            else
            begin
                out_re_reg <= res_re;
                out_im_reg <= res_im;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign sample_re = out_re_reg;
    assign sample_im = out_im_reg;

`ifndef SYNTHESIS
    // The skid register only fills behind a held output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid register filled without a stalled output");

    // Hold the gain stages while the skid register is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |=> $stable(vld_i_reg) && $stable(vld_j_reg))
        else $error("pipeline moved while frozen");

    // Hold the phase unless a sample was requested.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && in_ready && sample_request) |=> $stable(phase_reg))
        else $error("phase moved without a requested sample");
`endif

endmodule

`default_nettype wire

// File: rtl/twg_wave.sv
`default_nettype none

// Phase to unit-wave pipeline: seven stages, one phase in per enabled cycle.
module twg_wave (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [twg_pkg::PHASE_W-1:0]   phase,
    input  wire twg_pkg::mode_t                mode,
    output      logic                          out_valid,
    output      twg_pkg::wave_t                wave
);

    localparam int unsigned NSTEP = 5;
    localparam int unsigned OFS_BITS = twg_pkg::PHASE_W - 2;
    localparam int unsigned ZSH = 30 - OFS_BITS;
    localparam logic [twg_pkg::PHASE_W-1:0] QUARTER3 =
        twg_pkg::PHASE_W'(3 * twg_pkg::TABLE_SIZE / 4);

    // Horner coefficients in Q30: sine to z^9, cosine to z^10.
    localparam logic signed [31:0] SIN_INIT = 32'sd172272;
    localparam logic signed [31:0] COS_INIT = -32'sd27061;
    localparam logic signed [31:0] SIN_ADD [1:NSTEP] =
        '{-32'sd5026996, 32'sd85569303, -32'sd693598668, 32'sd1686629713, 32'sd0};
    localparam logic signed [31:0] COS_ADD [1:NSTEP] =
        '{32'sd987048, -32'sd22401991, 32'sd272375609, -32'sd1324675879,
          32'sd1073741824};

    // Q30 product, truncated toward zero.
    function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [63:0] prod;
        logic signed [63:0] adj;
        prod = a * b;
        adj = prod + (prod[63] ? 64'sd1073741823 : 64'sd0);
        return 32'(adj >>> 30);
    endfunction

    // Q30 to Q15, half away from zero, clamped to +-1.0.
    function automatic logic signed [twg_pkg::WAVE_W-1:0] to_q15(
        input logic signed [31:0] v);
        logic signed [32:0] v_ext;
        logic [32:0] mag;
        logic [32:0] sum;
        logic [17:0] r;
        logic [twg_pkg::WAVE_W-1:0] lim;
        v_ext = 33'(v);
        mag = v_ext[32] ? 33'(-v_ext) : 33'(v_ext);
        sum = mag + 33'd16384;
        r = sum[32:15];
        lim = (r > 18'd32768) ? twg_pkg::WAVE_W'(32768) : r[twg_pkg::WAVE_W-1:0];
        return v[31] ? -$signed(lim) : $signed(lim);
    endfunction

    // Ramp: round(32768*(2k-4095)/4095), half away from zero.
    // 32768*m/4095 = 8m + 8m/4095, and x/4095 = (x + x/4096 + 1)/4096 for x < 2^16.
    function automatic logic signed [twg_pkg::WAVE_W-1:0] ramp_val(
        input logic [twg_pkg::PHASE_W-1:0] k);
        logic [11:0] m;
        logic [15:0] x;
        logic [16:0] sum;
        logic [3:0]  qd;
        logic [15:0] mag;
        m = k[11] ? {k[10:0], 1'b1} : {~k[10:0], 1'b1};
        x = {1'b0, m, 3'b000} + 16'd2047;
        sum = {1'b0, x} + 17'({4'b0000, x[15:12]}) + 17'd1;
        qd = sum[15:12];
        mag = {1'b0, m, 3'b000} + 16'(qd);
        return k[11] ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
    endfunction

    function automatic logic signed [twg_pkg::WAVE_W-1:0] square_val(
        input logic [twg_pkg::PHASE_W-1:0] k);
        return k[twg_pkg::PHASE_W-1] ? twg_pkg::WAVE_ONE : '0;
    endfunction

    logic                      vld_reg  [0:NSTEP];
    logic [1:0]                quad_reg [0:NSTEP];
    twg_pkg::wave_t            alt_reg  [0:NSTEP];
    logic signed [31:0]        z_reg    [0:NSTEP-1];
    logic signed [31:0]        z2_reg   [0:NSTEP-1];
    logic signed [31:0]        sin_reg  [1:NSTEP];
    logic signed [31:0]        cos_reg  [1:NSTEP];
    logic signed [31:0]        sin_src  [1:NSTEP];
    logic signed [31:0]        cos_src  [1:NSTEP];
    logic signed [31:0]        sin_mul  [1:NSTEP];

    logic [twg_pkg::PHASE_W-1:0] phase_q;
    logic signed [31:0]          z_next;
    twg_pkg::wave_t              alt_next;
    logic signed [twg_pkg::WAVE_W-1:0] s_val;
    logic signed [twg_pkg::WAVE_W-1:0] c_val;
    twg_pkg::wave_t              rot;
    twg_pkg::wave_t              wave_next;
    logic                        valid_reg;
    twg_pkg::wave_t              wave_reg;

    assign phase_q = phase + QUARTER3;
    assign z_next = $signed({2'b00, phase[OFS_BITS-1:0], {ZSH{1'b0}}});

    // Shapes other than the cosine need no iteration: form them at entry.
    always_comb
    begin
        case (mode)
            twg_pkg::MODE_CONSTANT:
            begin
                alt_next.re = twg_pkg::WAVE_ONE;
                alt_next.im = '0;
            end
            twg_pkg::MODE_RAMP:
            begin
                alt_next.re = ramp_val(phase);
                alt_next.im = ramp_val(phase_q);
            end
            twg_pkg::MODE_SQUARE:
            begin
                alt_next.re = square_val(phase);
                alt_next.im = square_val(phase_q);
            end
            default:
            begin
                alt_next.re = '0;
                alt_next.im = '0;
            end
        endcase
    end

    // Sine's last step multiplies by z instead of z^2.
    always_comb
    begin
        sin_src[1] = SIN_INIT;
        cos_src[1] = COS_INIT;
        for (int s = 2; s <= NSTEP; s++)
        begin
            sin_src[s] = sin_reg[s-1];
            cos_src[s] = cos_reg[s-1];
        end
        for (int s = 1; s <= NSTEP; s++)
        begin
            sin_mul[s] = (s == NSTEP) ? z_reg[s-1] : z2_reg[s-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= NSTEP; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s <= NSTEP; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
            valid_reg <= vld_reg[NSTEP];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quad_reg[0] <= phase[twg_pkg::PHASE_W-1 -: 2];
            alt_reg[0]  <= alt_next;
            z_reg[0]    <= z_next;
            z2_reg[0]   <= mul_q30(z_next, z_next);
            for (int s = 1; s <= NSTEP; s++)
            begin
                quad_reg[s] <= quad_reg[s-1];
                alt_reg[s]  <= alt_reg[s-1];
                sin_reg[s]  <= mul_q30(sin_src[s], sin_mul[s]) + SIN_ADD[s];
                cos_reg[s]  <= mul_q30(cos_src[s], z2_reg[s-1]) + COS_ADD[s];
            end
            for (int s = 1; s < NSTEP; s++)
            begin
                z_reg[s]  <= z_reg[s-1];
                z2_reg[s] <= z2_reg[s-1];
            end
            wave_reg <= wave_next;
        end
    end

    assign s_val = to_q15(sin_reg[NSTEP]);
    assign c_val = to_q15(cos_reg[NSTEP]);

    // Rotate the first-quadrant pair into the quadrant of the phase.
    always_comb
    begin
        case (quad_reg[NSTEP])
            2'd0:
            begin
                rot.re = c_val;
                rot.im = s_val;
            end
            2'd1:
            begin
                rot.re = -s_val;
                rot.im = c_val;
            end
            2'd2:
            begin
                rot.re = -c_val;
                rot.im = -s_val;
            end
            default:
            begin
                rot.re = s_val;
                rot.im = -c_val;
            end
        endcase
    end

    assign wave_next = (mode == twg_pkg::MODE_COSINE) ? rot : alt_reg[NSTEP];

    assign out_valid = valid_reg;
    assign wave      = wave_reg;

endmodule

`default_nettype wire

// File: verif/table_waveform_generator_core_tb.sv
`default_nettype none

module table_waveform_generator_core_tb;

    localparam int OUT_W = 16;

    // Margin for the wave pipeline, the gain stages and the output buffer to empty.
    localparam int PIPE_SETTLE = 16;
    localparam int CYCLE_LIMIT = 400000;

    // Register indexes past the end of the map; the block must ignore writes there.
    localparam logic [twg_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [twg_pkg::CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

    // Fixed-point constants of the wave generator.
    localparam longint TURN      = longint'(twg_pkg::TABLE_SIZE);
    localparam longint Q15_ONE   = 32768;
    localparam longint Q30_ONE   = 1073741824;
    localparam longint SIN_C1    = 1686629713;
    localparam longint SIN_C3    = 693598668;
    localparam longint SIN_C5    = 85569303;
    localparam longint SIN_C7    = 5026996;
    localparam longint SIN_C9    = 172272;
    localparam longint COS_C2    = 1324675879;
    localparam longint COS_C4    = 272375609;
    localparam longint COS_C6    = 22401991;
    localparam longint COS_C8    = 987048;
    localparam longint COS_C10   = 27061;
    localparam longint OUT_MAX   = (64'sd1 <<< (OUT_W - 1)) - 1;
    localparam longint OUT_MIN   = -OUT_MAX - 1;
    localparam logic [twg_pkg::PHASE_W-1:0] THREE_QUARTER_TURN =
        twg_pkg::PHASE_W'(twg_pkg::TABLE_SIZE * 3 / 4);

    typedef struct packed {
        logic signed [OUT_W-1:0] re;
        logic signed [OUT_W-1:0] im;
    } sample_t;

    typedef struct {
        twg_pkg::mode_t                    mode;
        logic [twg_pkg::PHASE_W-1:0]       step;
        logic signed [twg_pkg::AMP_W-1:0]  amp_re;
        logic signed [twg_pkg::AMP_W-1:0]  amp_im;
        logic signed [twg_pkg::OFS_W-1:0]  ofs_re;
        logic signed [twg_pkg::OFS_W-1:0]  ofs_im;
    } nco_setting_t;

    // Shadow copy of the generator: registers, phase accumulator and the
    // queue of samples that the block still owes us.
    class nco_sample_tracker;
        twg_pkg::mode_t              mode;
        logic [twg_pkg::PHASE_W-1:0] step;
        logic [twg_pkg::PHASE_W-1:0] phase;
        longint                      amp_re;
        longint                      amp_im;
        longint                      ofs_re;
        longint                      ofs_im;
        sample_t                     owed_samples[$];
        int                          errors;

        function new();
            mode   = twg_pkg::MODE_CONSTANT;
            step   = '0;
            phase  = '0;
            amp_re = 32767;
            amp_im = 0;
            ofs_re = 0;
            ofs_im = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [twg_pkg::CFG_INDEX_W-1:0] idx,
                              logic [twg_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                twg_pkg::CFG_WAVEFORM_MODE: mode   = twg_pkg::mode_t'(data[1:0]);
                twg_pkg::CFG_PHASE_STEP:    step   = data[twg_pkg::PHASE_W-1:0];
                twg_pkg::CFG_AMPLITUDE_RE:  amp_re = longint'($signed(data[twg_pkg::AMP_W-1:0]));
                twg_pkg::CFG_AMPLITUDE_IM:  amp_im = longint'($signed(data[twg_pkg::AMP_W-1:0]));
                twg_pkg::CFG_OFFSET_RE:     ofs_re = longint'($signed(data[twg_pkg::OFS_W-1:0]));
                twg_pkg::CFG_OFFSET_IM:     ofs_im = longint'($signed(data[twg_pkg::OFS_W-1:0]));
                default: ;
            endcase
        endfunction

        // Q30 product, truncated toward zero (signed division does exactly that).
        function longint mul_q30(longint a, longint b);
            return (a * b) / Q30_ONE;
        endfunction

        // Divide with rounding half away from zero; den is positive.
        function longint round_div(longint num, longint den);
            longint mag;
            longint q;
            mag = (num < 0) ? -num : num;
            q   = (mag + den / 2) / den;
            return (num < 0) ? -q : q;
        endfunction

        function longint to_q15(longint v);
            longint r;
            r = round_div(v, Q15_ONE);
            if (r > Q15_ONE)
                r = Q15_ONE;
            if (r < -Q15_ONE)
                r = -Q15_ONE;
            return r;
        endfunction

        // cos + j sin by quadrant and Horner polynomials over the in-quadrant offset.
        function void cos_sin(logic [twg_pkg::PHASE_W-1:0] k, output longint wr,
                              output longint wi);
            longint     t;
            longint     z;
            longint     z2;
            longint     p;
            longint     q;
            longint     s;
            longint     c;
            logic [1:0] quad;
            t    = (longint'(k) * 1048576) / TURN;
            quad = t[19:18];
            z    = (t & 64'h3FFFF) << 12;
            z2   = mul_q30(z, z);

            p = SIN_C9;
            p = mul_q30(p, z2) - SIN_C7;
            p = mul_q30(p, z2) + SIN_C5;
            p = mul_q30(p, z2) - SIN_C3;
            p = mul_q30(p, z2) + SIN_C1;
            s = to_q15(mul_q30(p, z));

            q = -COS_C10;
            q = mul_q30(q, z2) + COS_C8;
            q = mul_q30(q, z2) - COS_C6;
            q = mul_q30(q, z2) + COS_C4;
            q = mul_q30(q, z2) - COS_C2;
            q = mul_q30(q, z2) + Q30_ONE;
            c = to_q15(q);

            case (quad)
                2'd0:
                begin
                    wr = c;
                    wi = s;
                end
                2'd1:
                begin
                    wr = -s;
                    wi = c;
                end
                2'd2:
                begin
                    wr = -c;
                    wi = -s;
                end
                default:
                begin
                    wr = s;
                    wi = -c;
                end
            endcase
        endfunction

        function longint ramp_at(logic [twg_pkg::PHASE_W-1:0] k);
            return round_div(Q15_ONE * (2 * longint'(k) - (TURN - 1)), TURN - 1);
        endfunction

        function longint square_at(logic [twg_pkg::PHASE_W-1:0] k);
            return (longint'(k) < TURN / 2) ? 0 : Q15_ONE;
        endfunction

        function logic signed [OUT_W-1:0] clamp_out(longint v);
            if (v > OUT_MAX)
                v = OUT_MAX;
            if (v < OUT_MIN)
                v = OUT_MIN;
            return v[OUT_W-1:0];
        endfunction

        // Note one accepted request; a clear request bit owes nothing and holds phase.
        function void note_request(logic req);
            logic [twg_pkg::PHASE_W-1:0] kq;
            longint                      wr;
            longint                      wi;
            longint                      re;
            longint                      im;
            sample_t                     s;
            if (!req)
                return;
            kq = phase + THREE_QUARTER_TURN;
            case (mode)
                twg_pkg::MODE_CONSTANT:
                begin
                    wr = Q15_ONE;
                    wi = 0;
                end
                twg_pkg::MODE_COSINE:
                begin
                    cos_sin(phase, wr, wi);
                end
                twg_pkg::MODE_RAMP:
                begin
                    wr = ramp_at(phase);
                    wi = ramp_at(kq);
                end
                default:
                begin
                    wr = square_at(phase);
                    wi = square_at(kq);
                end
            endcase
            re   = amp_re * wr - amp_im * wi;
            im   = amp_re * wi + amp_im * wr;
            s.re = clamp_out(round_div(re, Q15_ONE) + ofs_re);
            s.im = clamp_out(round_div(im, Q15_ONE) + ofs_im);
            owed_samples.push_back(s);
            phase = phase + step;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        // Compare one delivered sample against the oldest owed one.
        task check_sample(logic signed [OUT_W-1:0] re, logic signed [OUT_W-1:0] im);
            sample_t want;
            if (owed_samples.size() == 0)
            begin
                report($sformatf("sample re=%0d im=%0d with no request pending", re, im));
                return;
            end
            want = owed_samples.pop_front();
            if (re !== want.re)
                report($sformatf("sample_re got %0d want %0d", re, want.re));
            if (im !== want.im)
                report($sformatf("sample_im got %0d want %0d", im, want.im));
        endtask
    endclass

    logic                                   clk;
    logic                                   rst_n;
    logic                                   in_valid;
    logic                                   in_ready;
    logic                                   sample_request;
    logic                                   out_valid;
    logic                                   out_ready;
    logic signed [OUT_W-1:0]                sample_re;
    logic signed [OUT_W-1:0]                sample_im;
    logic                                   cfg_write;
    logic [twg_pkg::CFG_INDEX_W-1:0]        cfg_index;
    logic [twg_pkg::CFG_DATA_W-1:0]         cfg_data;

    nco_sample_tracker tracker;

    // Idle/stall odds in percent, set per phase by the stimulus.
    int send_idle_pct;
    int recv_stall_pct;
    // Remaining cycles of a forced receiver hold-off.
    int stall_left;
    int cycle_count;

    table_waveform_generator_core #(
        .OUT_WIDTH (OUT_W)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample_request (sample_request),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sample_re      (sample_re),
        .sample_im      (sample_im),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Receiver: drop ready at random, or hold it low through a forced hold-off.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: values read here are the ones sampled by this edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_sample(sample_re, sample_im);
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[table_waveform_generator_core] ERROR");
            $finish;
        end
    end

    // Write one register; hold the strobe one cycle, then drop it.
    task automatic write_reg(logic [twg_pkg::CFG_INDEX_W-1:0] idx,
                             logic [twg_pkg::CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        tracker.set_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic apply_setting(nco_setting_t s);
        write_reg(twg_pkg::CFG_WAVEFORM_MODE, twg_pkg::CFG_DATA_W'(s.mode));
        write_reg(twg_pkg::CFG_PHASE_STEP,    twg_pkg::CFG_DATA_W'(s.step));
        write_reg(twg_pkg::CFG_AMPLITUDE_RE,  s.amp_re);
        write_reg(twg_pkg::CFG_AMPLITUDE_IM,  s.amp_im);
        write_reg(twg_pkg::CFG_OFFSET_RE,     twg_pkg::CFG_DATA_W'(s.ofs_re));
        write_reg(twg_pkg::CFG_OFFSET_IM,     twg_pkg::CFG_DATA_W'(s.ofs_im));
    endtask

    // Offer one request; idle first at random, then hold valid until the transfer.
    task automatic send_request(logic req);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid       <= 1'b0;
            sample_request <= 1'($urandom_range(1));
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        sample_request <= req;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.note_request(req);
    endtask

    // Stop offering, wait for every owed sample, then let the pipeline empty
    // of requests that owe nothing.
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (tracker.owed_samples.size() != 0)
            @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    function automatic logic signed [twg_pkg::AMP_W-1:0] pick_amplitude();
        case ($urandom_range(5))
            0:       return 24'sh7FFFFF;
            1:       return 24'sh800000;
            2:       return twg_pkg::AMP_W'($signed($urandom_range(65535)) - 32768);
            default: return twg_pkg::AMP_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [twg_pkg::OFS_W-1:0] pick_offset();
        case ($urandom_range(4))
            0:       return '0;
            1:       return 16'sh7FFF;
            2:       return 16'sh8000;
            default: return twg_pkg::OFS_W'($urandom);
        endcase
    endfunction

    function automatic nco_setting_t pick_setting();
        nco_setting_t s;
        s.mode = twg_pkg::mode_t'($urandom_range(3));
        case ($urandom_range(6))
            0:       s.step = '0;
            1:       s.step = '1;
            2:       s.step = 12'd1;
            3:       s.step = 12'd2048;
            default: s.step = twg_pkg::PHASE_W'($urandom);
        endcase
        s.amp_re = pick_amplitude();
        s.amp_im = pick_amplitude();
        s.ofs_re = pick_offset();
        s.ofs_im = pick_offset();
        return s;
    endfunction

    initial
    begin
        nco_setting_t cfg;
        int           n_items;

        tracker        = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        sample_request = 1'b0;
        out_ready      = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        stall_left     = 0;
        cycle_count    = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset state: constant wave at the reset gain; a clear request owes nothing.
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b1);
        wait_for_idle();

        // Gain extremes drive both outputs into saturation, each way.
        cfg = '{twg_pkg::MODE_CONSTANT, 12'd0, 24'sh7FFFFF, 24'sh800000,
                16'sh7FFF, 16'sh8000};
        apply_setting(cfg);
        send_request(1'b1);
        wait_for_idle();
        cfg = '{twg_pkg::MODE_CONSTANT, 12'd0, 24'sh800000, 24'sh7FFFFF,
                16'sh8000, 16'sh7FFF};
        apply_setting(cfg);
        send_request(1'b1);
        wait_for_idle();

        // Cosine on the quadrant boundaries, phase starts from zero here.
        cfg = '{twg_pkg::MODE_COSINE, 12'd1024, 24'sd32767, 24'sd0, 16'sd0, 16'sd0};
        apply_setting(cfg);
        repeat (5) send_request(1'b1);
        wait_for_idle();

        // Four steps of 768 land the phase back on zero for the ramp ends.
        cfg = '{twg_pkg::MODE_COSINE, 12'd768, 24'sd20000, -24'sd12345,
                16'sd100, -16'sd100};
        apply_setting(cfg);
        repeat (4) send_request(1'b1);
        wait_for_idle();

        // Ramp at phase 0, 4095 and 4094.
        cfg = '{twg_pkg::MODE_RAMP, 12'd4095, 24'sd32767, 24'sd0, 16'sd0, 16'sd0};
        apply_setting(cfg);
        repeat (3) send_request(1'b1);
        wait_for_idle();

        cfg = '{twg_pkg::MODE_SQUARE, 12'd2048, -24'sd30000, 24'sd30000, 16'sd0, 16'sd0};
        apply_setting(cfg);
        repeat (2) send_request(1'b1);
        wait_for_idle();

        // Clear requests must hold the phase; writes past the map must change nothing.
        cfg = '{twg_pkg::MODE_RAMP, 12'd3, 24'sd32767, 24'sd0, 16'sd0, 16'sd0};
        apply_setting(cfg);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        wait_for_idle();
        write_reg(CFG_SPARE_LO, 24'hFFFFFF);
        write_reg(CFG_SPARE_HI, 24'h000003);
        send_request(1'b1);
        wait_for_idle();

        // Random phases: fresh setting each, rotating through the idle profiles.
        for (int ph = 0; ph < 12; ph++)
        begin
            cfg = pick_setting();
            apply_setting(cfg);
            if ($urandom_range(2) == 0)
                write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                          twg_pkg::CFG_DATA_W'($urandom));
            case (ph % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 71;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 71;
                end
                default:
                begin
                    send_idle_pct  = 34;
                    recv_stall_pct = 34;
                end
            endcase
            // Hold the receiver off long enough to back up the pipe and stall input.
            if (ph == 0 || ph == 8)
                stall_left <= 150;
            n_items = $urandom_range(30, 50);
            repeat (n_items)
                send_request($urandom_range(99) < 85);
            wait_for_idle();
        end

        if (tracker.errors == 0)
            $display("[table_waveform_generator_core] OK");
        else
            $display("[table_waveform_generator_core] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
